// ===== rtl/jcn_pkg.sv =====
// Shared types, constants and codes of the joystick calibrate and normalize block.
`default_nettype none

package jcn_pkg;

   localparam int NUM_CHANNELS_DEF = 4;
   localparam int SAMPLE_BITS_DEF  = 12;

   localparam int CH_BITS        = 2;
   localparam int OUT_BITS       = 12;
   localparam int FRAME_BITS     = 16;
   localparam int SPAN_BITS      = 12;
   localparam int MASK_BITS      = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int OUT_MAX        = (1 << OUT_BITS) - 1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_RECAL  = 1'b1;

   localparam logic [FRAME_BITS-1:0] RANGE_FRAMES_RST  = 16'd250;
   localparam logic [FRAME_BITS-1:0] SETTLE_FRAMES_RST = 16'd100;
   localparam logic [SPAN_BITS-1:0]  MIN_SPAN_RST      = 12'd1200;
   localparam logic [MASK_BITS-1:0]  REVERSE_MASK_RST  = 4'd9;
   localparam logic [OUT_BITS-1:0]   OUT_LOW_RST       = 12'd1000;
   localparam logic [OUT_BITS-1:0]   OUT_CENTER_RST    = 12'd1500;
   localparam logic [OUT_BITS-1:0]   OUT_HIGH_RST      = 12'd2000;

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_RANGE  = 2'd1,
      PH_MID    = 2'd2,
      PH_FINISH = 2'd3
   } cal_phase_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RANGE_FRAMES  = 3'd0,
      CSR_SETTLE_FRAMES = 3'd1,
      CSR_MIN_SPAN      = 3'd2,
      CSR_REVERSE_MASK  = 3'd3,
      CSR_OUT_LOW       = 3'd4,
      CSR_OUT_CENTER    = 3'd5,
      CSR_OUT_HIGH      = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CLAMP,
      ST_SETUP,
      ST_MULDIV,
      ST_ADD,
      ST_SAT,
      ST_FINISH
   } top_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_DONE
   } md_state_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] range_frames;
      logic [FRAME_BITS-1:0] settle_frames;
      logic [SPAN_BITS-1:0]  min_span;
      logic [MASK_BITS-1:0]  reverse_mask;
      logic [OUT_BITS-1:0]   out_low;
      logic [OUT_BITS-1:0]   out_center;
      logic [OUT_BITS-1:0]   out_high;
   } cfg_type;

   typedef struct packed {
      logic               apply;
      logic               recal;
      logic [CH_BITS-1:0] channel;
      logic               frame_end;
   } cal_cmd_type;

   typedef struct packed {
      logic          ch_ok;
      cal_phase_type next_phase;
      logic          save;
   } cal_status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_status_type;

endpackage

`default_nettype wire

// ===== rtl/jcn_if.sv =====
// Valid/ready channel interfaces: sample requests, results and register writes.
`default_nettype none

interface jcn_req_if
   import jcn_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [CH_BITS-1:0]     channel;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   frame_end;

   modport source (output valid, operation, channel, sample, frame_end, input ready);
   modport sink   (input valid, operation, channel, sample, frame_end, output ready);
endinterface

interface jcn_rsp_if
   import jcn_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CH_BITS-1:0]  out_channel;
   logic [OUT_BITS-1:0] scaled_value;
   logic                value_valid;
   cal_phase_type       phase;
   logic                save_request;

   modport source (output valid, out_channel, scaled_value, value_valid, phase, save_request,
                   input ready);
   modport sink   (input valid, out_channel, scaled_value, value_valid, phase, save_request,
                   output ready);
endinterface

interface jcn_csr_if
   import jcn_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/jcn_muldiv.sv =====
// Bit-serial unit: shift-add multiply, then restoring divide one quotient bit a cycle.
`default_nettype none

module jcn_muldiv
   import jcn_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [SAMPLE_BITS-1:0]          a,
   input  wire logic [OUT_BITS-1:0]             b,
   input  wire logic [SAMPLE_BITS-1:0]          d,
   output md_status_type                        status,
   output logic [SAMPLE_BITS+OUT_BITS-1:0]      q
);

   localparam int N_W   = SAMPLE_BITS + OUT_BITS;
   localparam int CNT_W = $clog2(N_W);

   md_state_type            state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [N_W-1:0]          mcand_ff, mcand_in;
   logic [OUT_BITS-1:0]     mplier_ff, mplier_in;
   logic [N_W-1:0]          acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0]  rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]  d_ff, d_in;
   logic [SAMPLE_BITS:0]    shifted;
   logic [SAMPLE_BITS+1:0]  trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      d_ff      <= d_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      d_in      = d_ff;
      shifted   = {rem_ff, acc_ff[N_W-1]};
      trial     = {1'b0, shifted} - {2'b00, d_ff};
      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               mcand_in  = N_W'(a);
               mplier_in = b;
               acc_in    = '0;
               rem_in    = '0;
               d_in      = d;
               cnt_in    = CNT_W'(OUT_BITS - 1);
               state_in  = MD_MUL;
            end
         end
         MD_MUL: begin
            // add the shifted multiplicand for each set multiplier bit
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[N_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[OUT_BITS-1:1]};
            if (cnt_ff == '0) begin
               cnt_in   = CNT_W'(N_W - 1);
               state_in = MD_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         MD_DIV: begin
            // product shifts out at the top, quotient bits shift in at the bottom
            if (!trial[SAMPLE_BITS+1]) begin
               rem_in = trial[SAMPLE_BITS-1:0];
               acc_in = {acc_ff[N_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[SAMPLE_BITS-1:0];
               acc_in = {acc_ff[N_W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = MD_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         MD_DONE: begin
            state_in = MD_IDLE;
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   assign status.busy = (state_ff != MD_IDLE);
   assign status.done = (state_ff == MD_DONE);
   assign q           = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/jcn_calib.sv =====
// Calibration sequencer: phase, frame counter and per-channel low/mid/high stores.
`default_nettype none

module jcn_calib
   import jcn_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cal_cmd_type            cmd,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire cfg_type                cfg,
   output cal_phase_type               phase,
   output cal_status_type              status,
   output logic [SAMPLE_BITS-1:0]      low_rd,
   output logic [SAMPLE_BITS-1:0]      mid_rd,
   output logic [SAMPLE_BITS-1:0]      high_rd
);

   localparam int CMP_W = ((SAMPLE_BITS > SPAN_BITS) ? SAMPLE_BITS : SPAN_BITS) + 1;
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
   localparam logic [SAMPLE_BITS-1:0] MID_SCALE  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   cal_phase_type          phase_ff, phase_in;
   logic [FRAME_BITS-1:0]  fc_ff, fc_in;
   logic [SAMPLE_BITS-1:0] low_ff  [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] high_ff [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] mid_ff  [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] low_in  [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] high_in [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] mid_in  [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] low_trk [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] high_trk[NUM_CHANNELS];
   logic [CMP_W-1:0]       span_diff[NUM_CHANNELS];
   logic                   ch_ok;
   logic                   spans_ok;
   logic                   save;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RANGE;
         fc_ff    <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            low_ff[c]  <= FULL_SCALE;
            high_ff[c] <= '0;
            mid_ff[c]  <= MID_SCALE;
         end
      end else begin
         phase_ff <= phase_in;
         fc_ff    <= fc_in;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            low_ff[c]  <= low_in[c];
            high_ff[c] <= high_in[c];
            mid_ff[c]  <= mid_in[c];
         end
      end
   end

   // store reads for the scaler and range tracking of phase 1
   always_comb begin
      ch_ok   = 32'(cmd.channel) < NUM_CHANNELS;
      low_rd  = low_ff[0];
      mid_rd  = mid_ff[0];
      high_rd = high_ff[0];
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         low_trk[c]  = low_ff[c];
         high_trk[c] = high_ff[c];
         if (32'(cmd.channel) == c) begin
            low_rd  = low_ff[c];
            mid_rd  = mid_ff[c];
            high_rd = high_ff[c];
            if (cmd.apply && !cmd.recal && phase_ff == PH_RANGE) begin
               if (sample < low_ff[c]) begin
                  low_trk[c] = sample;
               end
               if (sample > high_ff[c]) begin
                  high_trk[c] = sample;
               end
            end
         end
      end
   end

   // span check sees this beat's range update; a channel with high below low fails
   always_comb begin
      spans_ok = 1'b1;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         span_diff[c] = CMP_W'(high_trk[c]) - CMP_W'(low_trk[c]);
         if (span_diff[c][CMP_W-1] || span_diff[c] < CMP_W'(cfg.min_span)) begin
            spans_ok = 1'b0;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      fc_in    = fc_ff;
      save     = 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         low_in[c]  = low_ff[c];
         high_in[c] = high_ff[c];
         mid_in[c]  = mid_ff[c];
      end
      if (cmd.apply) begin
         if (cmd.recal) begin
            phase_in = PH_RANGE;
            fc_in    = '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               low_in[c]  = FULL_SCALE;
               high_in[c] = '0;
            end
         end else begin
            case (phase_ff)
               PH_NORMAL: begin
               end
               PH_FINISH: begin
                  if (cmd.frame_end) begin
                     phase_in = PH_NORMAL;
                     save     = 1'b1;
                  end
               end
               PH_RANGE, PH_MID: begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     low_in[c]  = low_trk[c];
                     high_in[c] = high_trk[c];
                     if (phase_ff == PH_MID && ch_ok && 32'(cmd.channel) == c &&
                         fc_ff > cfg.settle_frames) begin
                        mid_in[c] = sample;
                     end
                  end
                  if (cmd.frame_end) begin
                     if (fc_ff > cfg.range_frames && spans_ok) begin
                        phase_in = (phase_ff == PH_RANGE) ? PH_MID : PH_FINISH;
                        fc_in    = '0;
                     end else if (fc_ff != {FRAME_BITS{1'b1}}) begin
                        fc_in = fc_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   assign phase             = phase_ff;
   assign status.ch_ok      = ch_ok;
   assign status.next_phase = phase_in;
   assign status.save       = save;

endmodule

`default_nettype wire

// ===== rtl/joystick_calibrate_normalize_top.sv =====
// Top level of the joystick calibrate and normalize block.
// Calibration beats (recalibrate, phases 1 to 3, unknown channel) pass through the execute and finish states.
// Scaled beats in phase 0: clamp, setup, the serial unit, then add and saturate; the unit does
// a shift-add multiply and a restoring divide of one quotient bit per cycle.
// One beat in flight; the next is taken while a finished result waits in the output register.
// Synchronous active-high reset: phase 1, frame count zero, stores at full scale/zero/mid.
`default_nettype none

module joystick_calibrate_normalize_top
   import jcn_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   jcn_req_if.sink   req_bus,
   jcn_rsp_if.source rsp_bus,
   jcn_csr_if.sink   csr_bus
);

   localparam int N_W = SAMPLE_BITS + OUT_BITS;
   // quotient plus base and mirror headroom, signed
   localparam int R_W = N_W + 3;

   // control and configuration
   top_state_type state_ff, state_in;
   cfg_type       cfg_ff, cfg_in;

   // beat being worked on
   logic                   item_op_ff, item_op_in;
   logic [CH_BITS-1:0]     item_ch_ff, item_ch_in;
   logic [SAMPLE_BITS-1:0] item_sample_ff, item_sample_in;
   logic                   item_fe_ff, item_fe_in;

   // scaling datapath
   logic [SAMPLE_BITS-1:0]  v_ff, v_in;
   logic                    neg_ff, neg_in;
   logic                    den_zero_ff, den_zero_in;
   logic [OUT_BITS-1:0]     base_ff, base_in;
   logic signed [R_W-1:0]   r_ff, r_in;

   // finished result waiting for the output register
   logic [CH_BITS-1:0]  res_ch_ff, res_ch_in;
   logic [OUT_BITS-1:0] res_scaled_ff, res_scaled_in;
   logic                res_valid_ff, res_valid_in;
   cal_phase_type       res_phase_ff, res_phase_in;
   logic                res_save_ff, res_save_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CH_BITS-1:0]  rsp_ch_ff, rsp_ch_in;
   logic [OUT_BITS-1:0] rsp_scaled_ff, rsp_scaled_in;
   logic                rsp_vv_ff, rsp_vv_in;
   cal_phase_type       rsp_phase_ff, rsp_phase_in;
   logic                rsp_save_ff, rsp_save_in;

   // submodule links
   cal_cmd_type            cal_cmd;
   cal_status_type         cal_status;
   cal_phase_type          cal_phase;
   logic [SAMPLE_BITS-1:0] low_rd, mid_rd, high_rd;
   md_status_type          md_status;
   logic                   md_start;
   logic [N_W-1:0]         md_q;

   // setup and finishing arithmetic
   logic                    upper;
   logic [SAMPLE_BITS-1:0]  a_val;
   logic [SAMPLE_BITS:0]    den_s;
   logic [SAMPLE_BITS:0]    den_abs;
   logic [OUT_BITS:0]       b_s;
   logic [OUT_BITS:0]       b_abs;
   logic signed [R_W-1:0]   q_ext;
   logic signed [R_W-1:0]   q_s;
   logic signed [R_W-1:0]   mirrored;
   logic signed [R_W-1:0]   r_final;
   logic [OUT_BITS-1:0]     sat_value;
   logic                    req_fire;

   jcn_calib #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_calib (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cal_cmd),
      .sample  (item_sample_ff),
      .cfg     (cfg_ff),
      .phase   (cal_phase),
      .status  (cal_status),
      .low_rd  (low_rd),
      .mid_rd  (mid_rd),
      .high_rd (high_rd)
   );

   jcn_muldiv #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .a      (a_val),
      .b      (b_abs[OUT_BITS-1:0]),
      .d      (den_abs[SAMPLE_BITS-1:0]),
      .status (md_status),
      .q      (md_q)
   );

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_channel  = rsp_ch_ff;
   assign rsp_bus.scaled_value = rsp_scaled_ff;
   assign rsp_bus.value_valid  = rsp_vv_ff;
   assign rsp_bus.phase        = rsp_phase_ff;
   assign rsp_bus.save_request = rsp_save_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{range_frames:  RANGE_FRAMES_RST,
                           settle_frames: SETTLE_FRAMES_RST,
                           min_span:      MIN_SPAN_RST,
                           reverse_mask:  REVERSE_MASK_RST,
                           out_low:       OUT_LOW_RST,
                           out_center:    OUT_CENTER_RST,
                           out_high:      OUT_HIGH_RST};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      item_op_ff     <= item_op_in;
      item_ch_ff     <= item_ch_in;
      item_sample_ff <= item_sample_in;
      item_fe_ff     <= item_fe_in;
      v_ff           <= v_in;
      neg_ff         <= neg_in;
      den_zero_ff    <= den_zero_in;
      base_ff        <= base_in;
      r_ff           <= r_in;
      res_ch_ff      <= res_ch_in;
      res_scaled_ff  <= res_scaled_in;
      res_valid_ff   <= res_valid_in;
      res_phase_ff   <= res_phase_in;
      res_save_ff    <= res_save_in;
      rsp_ch_ff      <= rsp_ch_in;
      rsp_scaled_ff  <= rsp_scaled_in;
      rsp_vv_ff      <= rsp_vv_in;
      rsp_phase_ff   <= rsp_phase_in;
      rsp_save_ff    <= rsp_save_in;
   end

   // register writes; an index past the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_RANGE_FRAMES:  cfg_in.range_frames  = csr_bus.data[FRAME_BITS-1:0];
            CSR_SETTLE_FRAMES: cfg_in.settle_frames = csr_bus.data[FRAME_BITS-1:0];
            CSR_MIN_SPAN:      cfg_in.min_span      = csr_bus.data[SPAN_BITS-1:0];
            CSR_REVERSE_MASK:  cfg_in.reverse_mask  = csr_bus.data[MASK_BITS-1:0];
            CSR_OUT_LOW:       cfg_in.out_low       = csr_bus.data[OUT_BITS-1:0];
            CSR_OUT_CENTER:    cfg_in.out_center    = csr_bus.data[OUT_BITS-1:0];
            CSR_OUT_HIGH:      cfg_in.out_high      = csr_bus.data[OUT_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Segment setup from the clamped sample. Above the mid point the slope runs to high,
   // below it to low. Either segment can see a negative denominator (high under mid, or mid
   // under low, after a poor calibration), so carry signs apart and divide magnitudes: that
   // truncates toward zero.
   always_comb begin
      upper = (v_ff >= mid_rd);
      if (upper) begin
         a_val   = v_ff - mid_rd;
         den_s   = {1'b0, high_rd} - {1'b0, mid_rd};
         b_s     = {1'b0, cfg_ff.out_high} - {1'b0, cfg_ff.out_center};
         base_in = cfg_ff.out_center;
      end else begin
         a_val   = v_ff - low_rd;
         den_s   = {1'b0, mid_rd} - {1'b0, low_rd};
         b_s     = {1'b0, cfg_ff.out_center} - {1'b0, cfg_ff.out_low};
         base_in = cfg_ff.out_low;
      end
      den_abs     = den_s[SAMPLE_BITS] ? -den_s : den_s;
      b_abs       = b_s[OUT_BITS] ? -b_s : b_s;
      neg_in      = den_s[SAMPLE_BITS] ^ b_s[OUT_BITS];
      den_zero_in = (den_s == '0);
   end

   // Apply the sign and base, then mirror (reverse-mask channels) and saturate to the output range.
   always_comb begin
      q_ext = R_W'(md_q);
      q_s   = neg_ff ? -q_ext : q_ext;
      if (den_zero_ff) begin
         r_in = R_W'(cfg_ff.out_center);
      end else begin
         r_in = R_W'(base_ff) + q_s;
      end
      mirrored = R_W'(cfg_ff.out_low) + R_W'(cfg_ff.out_high) - r_ff;
      r_final  = cfg_ff.reverse_mask[item_ch_ff] ? mirrored : r_ff;
      if (r_final < 0) begin
         sat_value = '0;
      end else if (r_final > R_W'(OUT_MAX)) begin
         sat_value = OUT_BITS'(OUT_MAX);
      end else begin
         sat_value = r_final[OUT_BITS-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      item_op_in     = item_op_ff;
      item_ch_in     = item_ch_ff;
      item_sample_in = item_sample_ff;
      item_fe_in     = item_fe_ff;
      v_in           = v_ff;
      res_ch_in      = res_ch_ff;
      res_scaled_in  = res_scaled_ff;
      res_valid_in   = res_valid_ff;
      res_phase_in   = res_phase_ff;
      res_save_in    = res_save_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_ch_in      = rsp_ch_ff;
      rsp_scaled_in  = rsp_scaled_ff;
      rsp_vv_in      = rsp_vv_ff;
      rsp_phase_in   = rsp_phase_ff;
      rsp_save_in    = rsp_save_ff;
      md_start       = 1'b0;

      cal_cmd.apply     = 1'b0;
      cal_cmd.recal     = (item_op_ff == OP_RECAL);
      cal_cmd.channel   = item_ch_ff;
      cal_cmd.frame_end = item_fe_ff;

      // drop the output beat once taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_op_in     = req_bus.operation;
               item_ch_in     = req_bus.channel;
               item_sample_in = req_bus.sample;
               item_fe_in     = req_bus.frame_end;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (item_op_ff == OP_SAMPLE && cal_phase == PH_NORMAL && cal_status.ch_ok) begin
               state_in = ST_CLAMP;
            end else begin
               // calibration beat: update state and capture the report in the same cycle
               cal_cmd.apply = 1'b1;
               res_ch_in     = item_ch_ff;
               res_scaled_in = '0;
               res_valid_in  = 1'b0;
               res_phase_in  = cal_status.next_phase;
               res_save_in   = cal_status.save;
               state_in      = ST_FINISH;
            end
         end
         ST_CLAMP: begin
            // clamp to high, then to low, so low wins when the two cross
            v_in = item_sample_ff;
            if (item_sample_ff > high_rd) begin
               v_in = high_rd;
            end
            if (v_in < low_rd) begin
               v_in = low_rd;
            end
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            md_start = 1'b1;
            state_in = ST_MULDIV;
         end
         ST_MULDIV: begin
            if (md_status.done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            res_ch_in     = item_ch_ff;
            res_scaled_in = sat_value;
            res_valid_in  = 1'b1;
            res_phase_in  = PH_NORMAL;
            res_save_in   = 1'b0;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_ch_in     = res_ch_ff;
               rsp_scaled_in = res_scaled_ff;
               rsp_vv_in     = res_valid_ff;
               rsp_phase_in  = res_phase_ff;
               rsp_save_in   = res_save_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      md_start |-> !md_status.busy)
      else $error("serial unit started while busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_status.done |-> state_ff == ST_MULDIV)
      else $error("serial unit finished outside the wait state");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted beat not taken into execution");

   a_save_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_save_ff |-> rsp_phase_ff == PH_NORMAL && !rsp_vv_ff)
      else $error("save request outside a completed calibration");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_vv_ff |-> rsp_scaled_ff == '0)
      else $error("nonzero value on an invalid result");
`endif

endmodule

`default_nettype wire

// ===== verif/joystick_calibrate_normalize_top_tb.sv =====
// Self-checking testbench of the joystick calibrate and normalize block.
`timescale 1ns / 100ps

module joystick_calibrate_normalize_top_tb;
   import jcn_pkg::*;

   localparam int  HALF_PERIOD  = 5;
   localparam int  RESET_CYCLES = 9;
   localparam int  SETTLE_GAP   = 50;
   localparam int  BEATS_PER_MODE = 600;

   typedef struct packed {
      logic                       operation;
      logic [CH_BITS-1:0]         channel;
      logic [SAMPLE_BITS_DEF-1:0] sample;
      logic                       frame_end;
   } joy_beat_type;

   typedef struct packed {
      logic [CH_BITS-1:0]  out_channel;
      logic [OUT_BITS-1:0] scaled_value;
      logic                value_valid;
      cal_phase_type       phase;
      logic                save_request;
   } joy_result_type;

   // Tracks calibration state beat by beat and holds the results still owed by the block.
   class stick_scoreboard;
      cfg_type                    regs;
      cal_phase_type              phase_now;
      logic [FRAME_BITS-1:0]      frames_done;
      logic [SAMPLE_BITS_DEF-1:0] low_cal  [NUM_CHANNELS_DEF];
      logic [SAMPLE_BITS_DEF-1:0] high_cal [NUM_CHANNELS_DEF];
      logic [SAMPLE_BITS_DEF-1:0] mid_cal  [NUM_CHANNELS_DEF];
      logic                       cal_done;
      joy_result_type             pending_results[$];
      int                         mismatches;
      int                         results_seen;

      function new();
         regs.range_frames  = RANGE_FRAMES_RST;
         regs.settle_frames = SETTLE_FRAMES_RST;
         regs.min_span      = MIN_SPAN_RST;
         regs.reverse_mask  = REVERSE_MASK_RST;
         regs.out_low       = OUT_LOW_RST;
         regs.out_center    = OUT_CENTER_RST;
         regs.out_high      = OUT_HIGH_RST;
         foreach (mid_cal[c]) mid_cal[c] = 1 << (SAMPLE_BITS_DEF - 1);
         clear_range();
         mismatches   = 0;
         results_seen = 0;
      endfunction

      // Restart from range tracking; the mid points survive.
      function void clear_range();
         phase_now   = PH_RANGE;
         frames_done = '0;
         cal_done    = 1'b0;
         foreach (low_cal[c]) begin
            low_cal[c]  = '1;
            high_cal[c] = '0;
         end
      endfunction

      function void apply_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_RANGE_FRAMES:  regs.range_frames  = value;
            CSR_SETTLE_FRAMES: regs.settle_frames = value;
            CSR_MIN_SPAN:      regs.min_span      = value[SPAN_BITS-1:0];
            CSR_REVERSE_MASK:  regs.reverse_mask  = value[MASK_BITS-1:0];
            CSR_OUT_LOW:       regs.out_low       = value[OUT_BITS-1:0];
            CSR_OUT_CENTER:    regs.out_center    = value[OUT_BITS-1:0];
            CSR_OUT_HIGH:      regs.out_high      = value[OUT_BITS-1:0];
            default: ;
         endcase
      endfunction

      // A channel whose high lies below its low never passes.
      function bit spans_reached();
         foreach (low_cal[c])
            if (int'(high_cal[c]) - int'(low_cal[c]) < int'(regs.min_span)) return 1'b0;
         return 1'b1;
      endfunction

      // Clamp to [low, high] (low wins), then interpolate on the side of mid the value is on.
      function int map_sample(logic [CH_BITS-1:0] ch, logic [SAMPLE_BITS_DEF-1:0] raw);
         int v, lo, mid, hi, num, den;
         lo  = low_cal[ch];
         mid = mid_cal[ch];
         hi  = high_cal[ch];
         v   = raw;
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         if (v >= mid) begin
            num = (v - mid) * (int'(regs.out_high) - int'(regs.out_center));
            den = hi - mid;
         end else begin
            num = (v - lo) * (int'(regs.out_center) - int'(regs.out_low));
            den = mid - lo;
         end
         if (den == 0) return int'(regs.out_center);
         if (v >= mid) return int'(regs.out_center) + num / den;
         return int'(regs.out_low) + num / den;
      endfunction

      // Every channel index fits the four channels, so no beat is dropped as out of range.
      function joy_result_type calibrate_and_scale(joy_beat_type b);
         joy_result_type r;
         int             val;
         r = '0;
         r.out_channel = b.channel;
         if (b.operation == OP_RECAL) begin
            clear_range();
         end else if (phase_now == PH_NORMAL) begin
            val = map_sample(b.channel, b.sample);
            if (regs.reverse_mask[b.channel])
               val = int'(regs.out_low) + int'(regs.out_high) - val;
            if (val < 0) val = 0;
            if (val > OUT_MAX) val = OUT_MAX;
            r.scaled_value = val[OUT_BITS-1:0];
            r.value_valid  = 1'b1;
         end else if (phase_now == PH_FINISH) begin
            if (b.frame_end) begin
               cal_done       = 1'b1;
               r.save_request = 1'b1;
               phase_now      = PH_NORMAL;
            end
         end else begin
            if (phase_now == PH_RANGE) begin
               if (b.sample < low_cal[b.channel])  low_cal[b.channel]  = b.sample;
               if (b.sample > high_cal[b.channel]) high_cal[b.channel] = b.sample;
            end else if (frames_done > regs.settle_frames) begin
               mid_cal[b.channel] = b.sample;
            end
            if (b.frame_end) begin
               if (frames_done > regs.range_frames && spans_reached()) begin
                  phase_now   = (phase_now == PH_RANGE) ? PH_MID : PH_FINISH;
                  frames_done = '0;
               end else if (frames_done != '1) begin
                  frames_done = frames_done + 1'b1;
               end
            end
         end
         r.phase = phase_now;
         return r;
      endfunction

      function void note_beat(joy_beat_type b);
         pending_results.push_back(calibrate_and_scale(b));
      endfunction

      function void check_result(joy_result_type got);
         joy_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result ch %0d value %0d valid %0d phase %0d save %0d",
                        $time, got.out_channel, got.scaled_value, got.value_valid,
                        got.phase, got.save_request);
            return;
         end
         want = pending_results.pop_front();
         results_seen++;
         if (got.out_channel !== want.out_channel || got.scaled_value !== want.scaled_value ||
             got.value_valid !== want.value_valid || got.phase !== want.phase ||
             got.save_request !== want.save_request) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("%0t: result %0d mismatch (exp/got) ch %0d/%0d value %0d/%0d ",
                      $time, results_seen, want.out_channel, got.out_channel,
                      want.scaled_value, got.scaled_value);
               $display("valid %0d/%0d phase %0d/%0d save %0d/%0d",
                        want.value_valid, got.value_valid, want.phase, got.phase,
                        want.save_request, got.save_request);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   jcn_req_if req_bus ();
   jcn_rsp_if rsp_bus ();
   jcn_csr_if csr_bus ();

   joystick_calibrate_normalize_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   stick_scoreboard board = new();

   int             send_idle_pct   = 0;
   int             recv_idle_pct   = 0;
   int             rsp_hold_cycles = 0;
   int             beats_sent      = 0;
   joy_beat_type   seen_beat;
   joy_result_type seen_result;

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Receiver: burn down a hold-off first, otherwise drop ready at the current idle rate.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_bus.ready   <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitors: sample both channels on the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen_beat.operation = req_bus.operation;
            seen_beat.channel   = req_bus.channel;
            seen_beat.sample    = req_bus.sample;
            seen_beat.frame_end = req_bus.frame_end;
            board.note_beat(seen_beat);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_result.out_channel  = rsp_bus.out_channel;
            seen_result.scaled_value = rsp_bus.scaled_value;
            seen_result.value_valid  = rsp_bus.value_valid;
            seen_result.phase        = rsp_bus.phase;
            seen_result.save_request = rsp_bus.save_request;
            board.check_result(seen_result);
         end
      end
   end

   // Offer one beat, idling first at the sender's rate; return at the falling edge after it goes.
   task automatic send_beat(input int op, input int ch, input int smp, input int fend);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.operation = op[0];
      req_bus.channel   = ch[CH_BITS-1:0];
      req_bus.sample    = smp[SAMPLE_BITS_DEF-1:0];
      req_bus.frame_end = fend[0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      req_bus.valid = 1'b0;
      beats_sent++;
   endtask

   // Hold the sender until every owed result is back.
   task automatic wait_idle();
      while (board.pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value[CSR_DATA_BITS-1:0];
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      board.apply_register(idx, value[CSR_DATA_BITS-1:0]);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic apply_settings(input int range_f, input int settle_f, input int span,
                                 input int mask, input int lo, input int center, input int hi);
      wait_idle();
      write_reg(CSR_RANGE_FRAMES, range_f);
      write_reg(CSR_SETTLE_FRAMES, settle_f);
      write_reg(CSR_MIN_SPAN, span);
      write_reg(CSR_REVERSE_MASK, mask);
      write_reg(CSR_OUT_LOW, lo);
      write_reg(CSR_OUT_CENTER, center);
      write_reg(CSR_OUT_HIGH, hi);
   endtask

   function automatic int rand_sample();
      case ($urandom_range(9))
         0:       return 0;
         1:       return (1 << SAMPLE_BITS_DEF) - 1;
         default: return $urandom_range((1 << SAMPLE_BITS_DEF) - 1);
      endcase
   endfunction

   function automatic int rand_out();
      case ($urandom_range(9))
         0, 1:    return 0;
         2, 3:    return OUT_MAX;
         default: return $urandom_range(OUT_MAX);
      endcase
   endfunction

   // One sweep over all channels in rotated order; full-scale swings when asked.
   // Occasionally drop or duplicate the frame end to break the sequence.
   task automatic send_frame(input bit full_swing, input bit swing_sel);
      int rot, noise, ch, smp, fend;
      rot   = $urandom_range(NUM_CHANNELS_DEF - 1);
      noise = $urandom_range(99);
      for (int k = 0; k < NUM_CHANNELS_DEF; k++) begin
         ch   = (k + rot) % NUM_CHANNELS_DEF;
         smp  = full_swing ? ((swing_sel ^ ch[0]) ? OUT_MAX : 0) : rand_sample();
         fend = (k == NUM_CHANNELS_DEF - 1) ? (noise >= 5) :
                (noise < 10 && $urandom_range(3) == 0);
         send_beat(OP_SAMPLE, ch, smp, fend);
      end
   endtask

   // Usually recalibrate, walk the phases with random content up to a frame cap, then stream samples.
   task automatic calibration_session();
      int frames, range_frames_seen, frame_cap;
      frames            = 0;
      range_frames_seen = 0;
      frame_cap         = 3 * int'(board.regs.range_frames) + 12;
      if (frame_cap > 30) frame_cap = 30;
      if ($urandom_range(9) != 0)
         send_beat(OP_RECAL, $urandom_range(3), rand_sample(), $urandom_range(1));
      while (board.phase_now != PH_NORMAL && frames < frame_cap) begin
         if ($urandom_range(99) < 2)
            send_beat(OP_RECAL, $urandom_range(3), rand_sample(), $urandom_range(1));
         if (board.phase_now == PH_RANGE) range_frames_seen++;
         send_frame(board.phase_now == PH_RANGE && range_frames_seen <= 2 &&
                    $urandom_range(99) < 85, frames[0]);
         frames++;
      end
      repeat ($urandom_range(8, 30))
         send_beat(OP_SAMPLE, $urandom_range(3), rand_sample(), $urandom_range(1));
   endtask

   initial begin
      int random_start, sessions, drain_limit;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_SAMPLE;
      req_bus.channel   = '0;
      req_bus.sample    = '0;
      req_bus.frame_end = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_RANGE_FRAMES;
      csr_bus.data      = '0;
      rsp_bus.ready     = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 14;
      recv_idle_pct = 70;

      // Directed: short phases, and channel 3 left untouched so the first span check fails.
      write_reg(CSR_RANGE_FRAMES, 1);
      write_reg(CSR_SETTLE_FRAMES, 0);
      write_reg(CSR_MIN_SPAN, 2000);
      send_beat(OP_SAMPLE, 0, 0, 0);
      send_beat(OP_SAMPLE, 0, 4095, 0);
      send_beat(OP_SAMPLE, 1, 0, 0);
      send_beat(OP_SAMPLE, 1, 4095, 0);
      send_beat(OP_SAMPLE, 2, 0, 0);
      send_beat(OP_SAMPLE, 2, 4095, 1);
      send_beat(OP_SAMPLE, 0, 10, 1);
      send_beat(OP_SAMPLE, 0, 10, 1);        // frame count past range, span of channel 3 short
      send_beat(OP_SAMPLE, 3, 0, 0);
      send_beat(OP_SAMPLE, 3, 4095, 1);      // spans met: into mid capture
      send_beat(OP_SAMPLE, 0, 2048, 1);      // not yet past settle: mid kept
      send_beat(OP_SAMPLE, 0, 1000, 0);
      send_beat(OP_SAMPLE, 1, 0, 0);         // mid at low end
      send_beat(OP_SAMPLE, 2, 4095, 0);      // mid at high end
      send_beat(OP_SAMPLE, 3, 3000, 1);
      send_beat(OP_SAMPLE, 3, 3000, 1);      // into finishing
      send_beat(OP_SAMPLE, 0, 5, 0);         // ignored while finishing
      send_beat(OP_SAMPLE, 0, 5, 1);         // save request, calibrated
      send_beat(OP_SAMPLE, 0, 0, 0);         // below mid, mirrored
      send_beat(OP_SAMPLE, 0, 4095, 0);      // above mid, mirrored
      send_beat(OP_SAMPLE, 1, 0, 1);
      send_beat(OP_SAMPLE, 2, 4095, 0);      // zero denominator above mid
      send_beat(OP_SAMPLE, 2, 100, 0);
      send_beat(OP_SAMPLE, 3, 3500, 1);
      send_beat(OP_RECAL, 1, 4095, 1);       // recalibrate from normal operation

      // Random: three idling modes, each about a third of the beats.
      random_start = beats_sent;
      sessions     = 0;
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 14;
               recv_idle_pct = 70;
               // Stall the receiver long enough for the block to back up into its input.
               rsp_hold_cycles = 400;
            end
            1: begin
               // Pause the sender until every result is in.
               wait_idle();
               send_idle_pct = 70;
               recv_idle_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (beats_sent < random_start + BEATS_PER_MODE * (mode + 1)) begin
            if (sessions == 0)
               apply_settings(1, 0, 0, 15, 0, OUT_MAX, 0);
            else if (sessions == 1)
               apply_settings(1, 65535, 4095, 15, OUT_MAX, 0, OUT_MAX);
            else if ($urandom_range(99) < 35)
               apply_settings($urandom_range(9) < 7 ? $urandom_range(1, 3) : $urandom_range(1, 6),
                              $urandom_range(9) == 0 ? 65535 : $urandom_range(3),
                              $urandom_range(3) == 0 ? 4095 : $urandom_range(4095),
                              $urandom_range(15), rand_out(), rand_out(), rand_out());
            calibration_session();
            sessions++;
         end
      end

      // Drain, then watch a little longer for stray results.
      drain_limit = 0;
      while (board.pending_results.size() != 0 && drain_limit < 200000) begin
         @(negedge clock);
         drain_limit++;
      end
      repeat (SETTLE_GAP) @(negedge clock);

      if (board.mismatches == 0 && board.pending_results.size() == 0) begin
         $display("** joystick_calibrate_normalize_top: PASSED **");
      end else begin
         $display("** joystick_calibrate_normalize_top: FAILED **");
      end
      $finish;
   end

   // Watchdog: fail a run that does not finish.
   initial begin
      #20000000;
      $display("** joystick_calibrate_normalize_top: FAILED **");
      $finish;
   end

endmodule

// ===== joystick_calibrate_normalize_top.f =====
rtl/jcn_pkg.sv
rtl/jcn_if.sv
rtl/jcn_muldiv.sv
rtl/jcn_calib.sv
rtl/joystick_calibrate_normalize_top.sv
verif/joystick_calibrate_normalize_top_tb.sv
